[src/ica_pkg.sv]
// shared types, constants and arithmetic helpers for the attitude estimator
// no dependencies; imported by every module of the block
package ica_pkg;

  // serial multiplier: signed multiplicand, unsigned multiplier
  localparam int MUL_AW = 40;
  localparam int MUL_BW = 27;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MUL_CW = 5;

  // square root: 48-bit radicand, two radicand bits per cycle
  localparam int SQ_IN_W   = 48;
  localparam int SQ_ROOT_W = 24;
  localparam int SQ_REM_W  = 28;
  localparam int SQ_CW     = 5;

  // cordic datapath
  localparam int CORD_W  = 28;
  localparam int CORD_ZW = 33;
  localparam int ATAN_IW = 5;

  localparam logic [16:0] W_ONE        = 17'd65536;
  localparam logic [26:0] DEG2RAD_Q32  = 27'd74961321;
  localparam logic [26:0] DT_K_Q44     = 27'd307042;
  localparam longint      TWO_PI_Q30   = 64'sd6746518852;
  localparam longint      SAT_MAX      = 64'sd8388607;
  localparam longint      SAT_MIN      = -64'sd8388608;

  // configuration register indexes
  localparam logic [1:0] REG_PITCH_W   = 2'd0;
  localparam logic [1:0] REG_ROLL_W    = 2'd1;
  localparam logic [1:0] REG_PITCH_NEG = 2'd2;

  // arctangent of 2^-i in q30
  function automatic logic signed [CORD_ZW-1:0] atan_q30(logic [ATAN_IW-1:0] i);
    logic signed [CORD_ZW-1:0] v;
    case (i)
      5'd0:  v = 33'sd843314857;
      5'd1:  v = 33'sd497837829;
      5'd2:  v = 33'sd263043836;
      5'd3:  v = 33'sd133525158;
      5'd4:  v = 33'sd67021686;
      5'd5:  v = 33'sd33543515;
      5'd6:  v = 33'sd16775850;
      5'd7:  v = 33'sd8388437;
      5'd8:  v = 33'sd4194282;
      5'd9:  v = 33'sd2097149;
      5'd10: v = 33'sd1048575;
      5'd11: v = 33'sd524287;
      5'd12: v = 33'sd262143;
      5'd13: v = 33'sd131071;
      5'd14: v = 33'sd65535;
      5'd15: v = 33'sd32767;
      5'd16: v = 33'sd16383;
      5'd17: v = 33'sd8191;
      5'd18: v = 33'sd4095;
      5'd19: v = 33'sd2047;
      5'd20: v = 33'sd1023;
      5'd21: v = 33'sd511;
      5'd22: v = 33'sd255;
      5'd23: v = 33'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // arithmetic shift right with round half up
  function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int s);
    logic signed [63:0] h;
    h = 64'sd1 <<< (s - 1);
    return (v + h) >>> s;
  endfunction

  // clamp to the 24-bit signed range
  function automatic logic signed [23:0] sat24(logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > SAT_MAX) r = 24'sh7fffff;
    else if (v < SAT_MIN) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

[src/ica_serial_mul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on ica_pkg
module ica_serial_mul
  import ica_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [MUL_AW-1:0] a,
  input  logic        [MUL_BW-1:0] b,
  output logic                     done,
  output logic signed [MUL_PW-1:0] prod
);

  logic signed [MUL_AW-1:0] a_r;
  logic        [MUL_PW:0]   acc_r, acc_nxt;
  logic        [MUL_CW-1:0] cnt_r;
  logic                     busy_r, done_r;
  logic signed [MUL_AW:0]   hi, hi_sum;

  // add the multiplicand into the upper half when the low bit is set, then shift right one place
  always_comb begin
    hi      = acc_r[MUL_PW:MUL_BW];
    hi_sum  = acc_r[0] ? hi + (MUL_AW+1)'(a_r) : hi;
    acc_nxt = {hi_sum[MUL_AW], hi_sum, acc_r[MUL_BW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CW'(MUL_BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and product registers
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      acc_r <= {(MUL_AW+1)'(0), b};
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r[MUL_PW-1:0];

endmodule

[src/ica_sqrt.sv]
// digit-serial integer square root, two radicand bits per cycle
// depends on ica_pkg
module ica_sqrt
  import ica_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SQ_IN_W-1:0]   radicand,
  output logic                 done,
  output logic [SQ_ROOT_W-1:0] root
);

  logic [SQ_IN_W-1:0]   n_r;
  logic [SQ_REM_W-1:0]  rem_r, rem_sh, trial;
  logic [SQ_ROOT_W-1:0] root_r;
  logic [SQ_CW-1:0]     cnt_r;
  logic                 busy_r, done_r;
  logic                 fits;

  // trial subtraction for the next root bit
  always_comb begin
    rem_sh = {rem_r[SQ_REM_W-3:0], n_r[SQ_IN_W-1:SQ_IN_W-2]};
    trial  = {2'b00, root_r, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SQ_CW'(SQ_ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= {n_r[SQ_IN_W-3:0], 2'b00};
      rem_r  <= fits ? rem_sh - trial : rem_sh;
      root_r <= {root_r[SQ_ROOT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[src/ica_cordic.sv]
// iterative vectoring cordic, one micro-rotation per cycle, q30 angle
// depends on ica_pkg
module ica_cordic
  import ica_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [CORD_W-1:0]  x0,
  input  logic signed [CORD_W-1:0]  y0,
  output logic                      done,
  output logic signed [CORD_ZW-1:0] z
);

  logic signed [CORD_W-1:0]  x_r, y_r, dx, dy;
  logic signed [CORD_ZW-1:0] z_r, ang;
  logic [ATAN_IW-1:0]        cnt_r;
  logic                      busy_r, done_r;

  always_comb begin
    dx  = y_r >>> cnt_r;
    dy  = x_r >>> cnt_r;
    ang = atan_q30(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ATAN_IW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x0;
      y_r <= y0;
      z_r <= '0;
    end else if (busy_r) begin
      if (!y_r[CORD_W-1]) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + ang;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - ang;
      end
    end
  end

  assign done = done_r;
  assign z    = z_r;

endmodule

[src/imu_complementary_attitude.sv]
// top level of the complementary-filter attitude estimator
// depends on ica_pkg, ica_serial_mul, ica_sqrt and ica_cordic
//
// One item is processed at a time. Each item runs a fixed sequence on three
// shared units: a bit-serial multiplier, a square root and a cordic. A normal
// item needs 17 products, two roots and two cordic runs; a seed item skips
// the integration and blending. The input is ready again once the result is
// in the output register, so the next item may start while the result waits.
module imu_complementary_attitude
  import ica_pkg::*;
#(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // fields low to high: accel_x, accel_y, accel_z, rate_x_dps, rate_y_dps,
  // rate_z_dps, elapsed_us, zero fill
  input  logic [119:0] in_tdata,
  // fields: seed_from_accel
  input  logic         in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // fields low to high: pitch_rad, roll_rad, yaw_rad, roll_rate_rads,
  // pitch_rate_rads, yaw_rate_rads
  output logic [143:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data
);

  localparam int     RTS    = 32 - ANGLE_FRAC_BITS;
  localparam int     DTS    = 44 - ANGLE_FRAC_BITS;
  localparam int     ZS     = 30 - ANGLE_FRAC_BITS;
  localparam longint TWO_PI = rnd_shift(TWO_PI_Q30, ZS);

  // sequence steps
  localparam logic [4:0] OP_SQ_P0  = 5'd0;
  localparam logic [4:0] OP_SQ_P1  = 5'd1;
  localparam logic [4:0] OP_RT_P   = 5'd2;
  localparam logic [4:0] OP_CD_P   = 5'd3;
  localparam logic [4:0] OP_SQ_R0  = 5'd4;
  localparam logic [4:0] OP_SQ_R1  = 5'd5;
  localparam logic [4:0] OP_RT_R   = 5'd6;
  localparam logic [4:0] OP_CD_R   = 5'd7;
  localparam logic [4:0] OP_RATE_X = 5'd8;
  localparam logic [4:0] OP_RATE_Y = 5'd9;
  localparam logic [4:0] OP_RATE_Z = 5'd10;
  localparam logic [4:0] OP_DT_X   = 5'd11;
  localparam logic [4:0] OP_K_X    = 5'd12;
  localparam logic [4:0] OP_DT_Y   = 5'd13;
  localparam logic [4:0] OP_K_Y    = 5'd14;
  localparam logic [4:0] OP_DT_Z   = 5'd15;
  localparam logic [4:0] OP_K_Z    = 5'd16;
  localparam logic [4:0] OP_BL_P0  = 5'd17;
  localparam logic [4:0] OP_BL_P1  = 5'd18;
  localparam logic [4:0] OP_BL_R0  = 5'd19;
  localparam logic [4:0] OP_BL_R1  = 5'd20;
  localparam logic [4:0] OP_FIN    = 5'd21;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state_r;
  logic [4:0] op_r;

  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic        [19:0] dt_r;
  logic               seed_r;

  logic [16:0] pw_r, rw_r;
  logic        neg_r;

  logic signed [23:0] pitch_r, roll_r, yaw_r;
  logic signed [23:0] acc_p_r, acc_r_r;
  logic signed [23:0] rx_r, ry_r, rz_r;
  logic        [31:0] sq_r, ss_r;
  logic signed [35:0] tdt_r;
  logic signed [31:0] dp_r, dr_r, dy_r;
  logic signed [49:0] m_r;

  logic [143:0] out_tdata_r;
  logic         out_tvalid_r;

  // unit wiring
  logic                      mul_start, sq_start, cd_start;
  logic                      mul_done, sq_done, cd_done, unit_done;
  logic signed [MUL_AW-1:0]  mul_a;
  logic        [MUL_BW-1:0]  mul_b;
  logic signed [MUL_PW-1:0]  prod;
  logic        [SQ_ROOT_W-1:0] root;
  logic signed [CORD_W-1:0]  cd_x0, cd_y0;
  logic signed [CORD_ZW-1:0] cd_z;
  logic signed [15:0]        cd_num;

  logic is_sqrt, is_cord, is_fin;
  logic [16:0] wwp, wwr;
  logic signed [32:0] gp, gr;
  logic signed [63:0] prod64, blend_v, yv;
  logic in_xfer;
  logic fin_fire;

  function automatic logic [15:0] mag16(logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  assign in_xfer   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // step decode
  assign is_sqrt = (op_r == OP_RT_P) || (op_r == OP_RT_R);
  assign is_cord = (op_r == OP_CD_P) || (op_r == OP_CD_R);
  assign is_fin  = (op_r == OP_FIN);

  assign mul_start = (state_r == S_START) && !is_sqrt && !is_cord && !is_fin;
  assign sq_start  = (state_r == S_START) && is_sqrt;
  assign cd_start  = (state_r == S_START) && is_cord;
  assign unit_done = is_sqrt ? sq_done : (is_cord ? cd_done : mul_done);

  // result register loads when it is empty or being emptied
  assign fin_fire = (state_r == S_FIN) && (!out_tvalid_r || out_tready);

  // clamped weights and gyro-path angles
  assign wwp = (pw_r > W_ONE) ? W_ONE : pw_r;
  assign wwr = (rw_r > W_ONE) ? W_ONE : rw_r;
  assign gp  = 33'(pitch_r) + 33'(dp_r);
  assign gr  = 33'(roll_r) + 33'(dr_r);
  assign prod64 = prod[63:0];

  // multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_SQ_P0: begin
        mul_a = MUL_AW'(mag16(ay_r));
        mul_b = MUL_BW'(mag16(ay_r));
      end
      OP_SQ_P1, OP_SQ_R1: begin
        mul_a = MUL_AW'(mag16(az_r));
        mul_b = MUL_BW'(mag16(az_r));
      end
      OP_SQ_R0: begin
        mul_a = MUL_AW'(mag16(ax_r));
        mul_b = MUL_BW'(mag16(ax_r));
      end
      OP_RATE_X: begin
        mul_a = MUL_AW'(gx_r);
        mul_b = DEG2RAD_Q32;
      end
      OP_RATE_Y: begin
        mul_a = MUL_AW'(gy_r);
        mul_b = DEG2RAD_Q32;
      end
      OP_RATE_Z: begin
        mul_a = MUL_AW'(gz_r);
        mul_b = DEG2RAD_Q32;
      end
      OP_DT_X: begin
        mul_a = MUL_AW'(gx_r);
        mul_b = MUL_BW'(dt_r);
      end
      OP_DT_Y: begin
        mul_a = MUL_AW'(gy_r);
        mul_b = MUL_BW'(dt_r);
      end
      OP_DT_Z: begin
        mul_a = MUL_AW'(gz_r);
        mul_b = MUL_BW'(dt_r);
      end
      OP_K_X, OP_K_Y, OP_K_Z: begin
        mul_a = MUL_AW'(tdt_r);
        mul_b = DT_K_Q44;
      end
      OP_BL_P0: begin
        mul_a = MUL_AW'(gp);
        mul_b = MUL_BW'(W_ONE - wwp);
      end
      OP_BL_P1: begin
        mul_a = MUL_AW'(acc_p_r);
        mul_b = MUL_BW'(wwp);
      end
      OP_BL_R0: begin
        mul_a = MUL_AW'(gr);
        mul_b = MUL_BW'(W_ONE - wwr);
      end
      OP_BL_R1: begin
        mul_a = MUL_AW'(acc_r_r);
        mul_b = MUL_BW'(wwr);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // cordic operands: q8 vector from the root and the numerator
  assign cd_num = (op_r == OP_CD_P) ? ax_r : ay_r;
  assign cd_x0  = CORD_W'(root);
  assign cd_y0  = {{(CORD_W-24){cd_num[15]}}, cd_num, 8'b0};

  // blend sum and yaw wrap
  always_comb begin
    if (op_r == OP_BL_P1 && neg_r) blend_v = 64'(m_r) - prod64;
    else blend_v = 64'(m_r) + prod64;
    yv = 64'(yaw_r);
    if (yv < 0) yv = yv + TWO_PI;
    if (yv > TWO_PI) yv = yv - TWO_PI;
  end

  ica_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  ica_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({ss_r, 16'b0}),
    .done     (sq_done),
    .root     (root)
  );

  ica_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cd_start),
    .x0    (cd_x0),
    .y0    (cd_y0),
    .done  (cd_done),
    .z     (cd_z)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r  <= 17'd66;
      rw_r  <= 17'd328;
      neg_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PITCH_W:   pw_r  <= cfg_data;
        REG_ROLL_W:    rw_r  <= cfg_data;
        REG_PITCH_NEG: neg_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ax_r   <= in_tdata[15:0];
      ay_r   <= in_tdata[31:16];
      az_r   <= in_tdata[47:32];
      gx_r   <= in_tdata[63:48];
      gy_r   <= in_tdata[79:64];
      gz_r   <= in_tdata[95:80];
      dt_r   <= in_tdata[115:96];
      seed_r <= in_tuser;
    end
  end

  // step results
  always_ff @(posedge clk) begin
    if (state_r == S_WAIT && unit_done) begin
      case (op_r)
        OP_SQ_P0, OP_SQ_R0: sq_r <= prod[31:0];
        OP_SQ_P1, OP_SQ_R1: ss_r <= sq_r + prod[31:0];
        OP_CD_P: acc_p_r <= (ax_r == 16'sd0) ? '0 : 24'(rnd_shift(64'(cd_z), ZS));
        OP_CD_R: acc_r_r <= (ay_r == 16'sd0) ? '0 : 24'(rnd_shift(64'(cd_z), ZS));
        OP_RATE_X: rx_r <= sat24(rnd_shift(prod64, RTS));
        OP_RATE_Y: ry_r <= sat24(rnd_shift(prod64, RTS));
        OP_RATE_Z: rz_r <= sat24(rnd_shift(prod64, RTS));
        OP_DT_X, OP_DT_Y, OP_DT_Z: tdt_r <= prod[35:0];
        OP_K_X: dr_r <= 32'(rnd_shift(prod64, DTS));
        OP_K_Y: dp_r <= 32'(rnd_shift(prod64, DTS));
        OP_K_Z: dy_r <= 32'(rnd_shift(prod64, DTS));
        OP_BL_P0, OP_BL_R0: m_r <= prod[49:0];
        default: ;
      endcase
    end
  end

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= OP_SQ_P0;
      pitch_r      <= 24'sd65536;
      roll_r       <= 24'sd65536;
      yaw_r        <= 24'sd65536;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && !fin_fire) out_tvalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r    <= OP_SQ_P0;
            state_r <= S_START;
          end
        end
        S_START: begin
          state_r <= is_fin ? S_FIN : S_WAIT;
        end
        S_WAIT: begin
          if (unit_done) begin
            if (op_r == OP_BL_P1) pitch_r <= sat24(rnd_shift(blend_v, 16));
            if (op_r == OP_BL_R1) begin
              roll_r <= sat24(rnd_shift(blend_v, 16));
              yaw_r  <= sat24(yv + 64'(dy_r));
            end
            op_r    <= (op_r == OP_RATE_Z && seed_r) ? OP_FIN : op_r + 5'd1;
            state_r <= S_START;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            if (seed_r) begin
              pitch_r <= acc_p_r;
              roll_r  <= acc_r_r;
            end
            out_tdata_r  <= {rz_r, ry_r, rx_r, yaw_r,
                             seed_r ? acc_r_r : roll_r,
                             seed_r ? acc_p_r : pitch_r};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  // a waiting result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an accepted item blocks the input until it is done
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input ready right after a transfer");

  // one shared unit is started at a time
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mul_start, sq_start, cd_start}))
    else $error("two units started together");

endmodule

[verif/testbench.sv]
// self-checking testbench for imu_complementary_attitude
// depends on ica_pkg (register indexes and arctangent table) and the block's top-level module
module testbench;
  import ica_pkg::*;

  typedef struct packed {
    logic        seed;
    logic [19:0] dt_us;
    logic [15:0] gz;
    logic [15:0] gy;
    logic [15:0] gx;
    logic [15:0] az;
    logic [15:0] ay;
    logic [15:0] ax;
  } imu_sample_t;

  // predicts the filtered attitude and rates and holds the results still due
  class attitude_scoreboard;
    longint      pitch_st, roll_st, yaw_st;
    logic [16:0] w_pitch, w_roll;
    bit          pitch_neg;
    logic [143:0] attitude_q[$];
    int          errors, mismatches;

    function new();
      pitch_st = 65536; roll_st = 65536; yaw_st = 65536;
      w_pitch = 17'd66; w_roll = 17'd328; pitch_neg = 1;
      errors = 0; mismatches = 0;
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clamp24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function longint int_sqrt(longint n);
      longint r, b;
      r = 0; b = 64'sd1 <<< 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >>> 1) + b;
        end else begin
          r = r >>> 1;
        end
        b = b >>> 2;
      end
      return r;
    endfunction

    // vectoring cordic of atan2(num, sqrt(p^2 + q^2)), q16 result
    function longint tilt_angle(longint num, longint p, longint q);
      longint x, y, z, dx, dy;
      x = int_sqrt((p * p + q * q) <<< 16);
      y = num * 256;
      z = 0;
      if (num == 0) return 0;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += longint'(atan_q30(i[4:0]));
        end else begin
          x -= dx; y += dy; z -= longint'(atan_q30(i[4:0]));
        end
      end
      return round_shift(z, 14);
    endfunction

    function longint mix(longint g, longint a, logic [16:0] w, bit neg);
      longint ww, acc;
      ww = (w > 17'd65536) ? 65536 : longint'(w);
      acc = g * (65536 - ww);
      if (neg) acc -= a * ww;
      else acc += a * ww;
      return clamp24(round_shift(acc, 16));
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] v);
      case (idx)
        REG_PITCH_W:   w_pitch = v;
        REG_ROLL_W:    w_roll = v;
        REG_PITCH_NEG: pitch_neg = v[0];
        default: ;
      endcase
    endfunction

    function void note_sample(imu_sample_t s);
      longint ax, ay, az, gx, gy, gz, dt, acc_p, acc_r, two_pi, yv;
      logic [23:0] rr, rp, ry;
      ax = longint'($signed(s.ax)); ay = longint'($signed(s.ay));
      az = longint'($signed(s.az)); gx = longint'($signed(s.gx));
      gy = longint'($signed(s.gy)); gz = longint'($signed(s.gz));
      dt = longint'(s.dt_us);
      acc_p = tilt_angle(ax, ay, az);
      acc_r = tilt_angle(ay, ax, az);
      two_pi = round_shift(64'sd6746518852, 14);
      rr = 24'(clamp24(round_shift(gx * 74961321, 16)));
      rp = 24'(clamp24(round_shift(gy * 74961321, 16)));
      ry = 24'(clamp24(round_shift(gz * 74961321, 16)));
      if (s.seed) begin
        pitch_st = clamp24(acc_p);
        roll_st = clamp24(acc_r);
      end else begin
        pitch_st = mix(pitch_st + round_shift(gy * dt * 307042, 28), acc_p,
                       w_pitch, pitch_neg);
        roll_st = mix(roll_st + round_shift(gx * dt * 307042, 28), acc_r,
                      w_roll, 1'b0);
        // yaw wraps into 0..2pi once, then integrates
        yv = yaw_st;
        if (yv < 0) yv += two_pi;
        if (yv > two_pi) yv -= two_pi;
        yaw_st = clamp24(yv + round_shift(gz * dt * 307042, 28));
      end
      attitude_q.push_back({ry, rp, rr, yaw_st[23:0], roll_st[23:0],
                            pitch_st[23:0]});
    endfunction

    function void check_result(logic [143:0] got);
      logic [143:0] exp_v;
      if (attitude_q.size() == 0) begin
        errors++;
        $display("unexpected result %h", got);
        return;
      end
      exp_v = attitude_q.pop_front();
      for (int f = 0; f < 6; f++) begin
        if (got[f*24 +: 24] !== exp_v[f*24 +: 24]) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch field %0d: expected %h actual %h", f,
                     exp_v[f*24 +: 24], got[f*24 +: 24]);
        end
      end
    endfunction
  endclass

  logic         clk, rst_n;
  logic [119:0] in_tdata;
  logic         in_tuser, in_tvalid, in_tready;
  logic [143:0] out_tdata;
  logic         out_tvalid, out_tready;
  logic         cfg_valid, cfg_ready;
  logic [1:0]   cfg_index;
  logic [16:0]  cfg_data;

  attitude_scoreboard sb = new();
  int  rx_mode = 0;
  int  rx_hold = 0;
  int  rx_phase = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  bit  tx_gaps = 1;
  int  burst_left = 0;

  imu_complementary_attitude DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("[imu_complementary_attitude] ERROR");
    $finish;
  end

  // receiver stall pattern, with an on-demand long hold-off
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      rx_hold <= 3000;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 9) < 7);
        default: out_tready <= ((rx_phase % 8) < 3);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_sample(imu_sample_t s);
    int gap;
    in_tdata <= {4'b0, s.dt_us, s.gz, s.gy, s.gx, s.az, s.ay, s.ax};
    in_tuser <= s.seed;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 30);
      if (tx_gaps) begin
        gap = $urandom_range(1, 40);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drain();
    while (sb.attitude_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [16:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
  endtask

  task automatic set_filter(logic [16:0] wp, logic [16:0] wr, logic neg);
    in_tvalid <= 1'b0;
    wait_drain();
    write_cfg(REG_PITCH_W, wp);
    write_cfg(REG_ROLL_W, wr);
    write_cfg(REG_PITCH_NEG, {16'b0, neg});
    cfg_valid <= 1'b0;
  endtask

  function automatic imu_sample_t mk(int ax, int ay, int az, int gx, int gy,
                                     int gz, int dt, bit seed);
    imu_sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
    s.dt_us = 20'(dt); s.seed = seed;
    return s;
  endfunction

  // mostly plausible motion with random content, some raw noise
  function automatic imu_sample_t rand_sample();
    imu_sample_t s;
    s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
    s.gx = 16'($urandom); s.gy = 16'($urandom); s.gz = 16'($urandom);
    s.dt_us = 20'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      s.dt_us = 20'($urandom_range(500, 2000));
      s.gx = $signed(s.gx) >>> $urandom_range(0, 8);
      s.gy = $signed(s.gy) >>> $urandom_range(0, 8);
      s.gz = $signed(s.gz) >>> $urandom_range(0, 8);
    end
    if ($urandom_range(0, 9) == 0) s.ax = 0;
    if ($urandom_range(0, 9) == 0) s.ay = 0;
    s.seed = ($urandom_range(0, 19) == 0);
    return s;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_sample(rand_sample());
  endtask

  initial begin
    rst_n = 0;
    in_tdata = '0; in_tuser = 0; in_tvalid = 0;
    out_tready = 0;
    cfg_valid = 0; cfg_index = REG_PITCH_W; cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero numerators, seeding, yaw wrap both ways
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(mk(0, 0, 0, 0, 0, 0, 1000, 1));
    send_sample(mk(0, 1000, 0, 10, 20, 30, 1000, 0));
    send_sample(mk(1000, 0, 0, -10, -20, -30, 1000, 0));
    send_sample(mk(0, 0, 16384, 0, 0, 0, 1000, 0));
    send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767, 1048575, 0));
    send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, 1048575, 0));
    send_sample(mk(-32768, 0, 0, 0, 0, 0, 0, 1));
    send_sample(mk(32767, -32768, 0, 100, -100, 0, 0, 1));
    send_sample(mk(0, 0, -32768, 0, 0, -32768, 1048575, 0));
    send_sample(mk(0, 0, 16384, 0, 0, 100, 1000, 0));
    send_sample(mk(0, 0, 16384, 0, 0, 32767, 1048575, 0));
    send_sample(mk(0, 0, 16384, 0, 0, 0, 1000, 0));
    send_sample(mk(1, -1, 1, 1, -1, 1, 1, 0));
    send_sample(mk(-1, 1, -1, -1, 1, -1, 1048575, 1));
    send_sample(mk(12000, -9000, 14000, 250, -250, 500, 1000, 0));
    run_random(250);

    rx_mode = 1;
    set_filter(17'd0, 17'd0, 1'b0);
    run_random(250);
    set_filter(17'd65536, 17'd65536, 1'b1);
    run_random(250);

    // weights above one
    rx_mode = 2;
    tx_gaps = 0;
    set_filter(17'h1ffff, 17'd100000, 1'b0);
    run_random(250);

    // long receiver hold-off while the sender keeps offering
    rx_mode = 1;
    tx_gaps = 1;
    set_filter(17'($urandom), 17'($urandom), 1'($urandom));
    hold_req <= 1'b1;
    run_random(400);

    // sender pauses until everything is back, then resumes
    rx_mode = 0;
    set_filter(17'd66, 17'd328, 1'b1);
    run_random(200);
    in_tvalid <= 1'b0;
    wait_drain();
    rx_mode = 1;
    run_random(200);

    in_tvalid <= 1'b0;
    wait_drain();
    repeat (700) @(posedge clk);
    if (sb.errors == 0 && sb.attitude_q.size() == 0) begin
      $display("[imu_complementary_attitude] OK");
    end else begin
      $display("[imu_complementary_attitude] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/ica_pkg.sv
src/ica_serial_mul.sv
src/ica_sqrt.sv
src/ica_cordic.sv
src/imu_complementary_attitude.sv
verif/testbench.sv
